// ----- sv/hbbc_pkg.sv -----
// ----------------------------------------------------------------------------
// hbbc_pkg
// Shared sizes, codes and record types of the hashed block buffer cache.
// ----------------------------------------------------------------------------
package hbbc_pkg;

    localparam int SLOTS    = 32;
    localparam int BUCKETS  = 13;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int RANK_W   = SLOT_W;
    localparam int BKT_W    = $clog2(BUCKETS);
    localparam int DEV_W    = 8;
    localparam int BLK_W    = 32;
    localparam int REFS_W   = 8;
    localparam int KIND_W   = 2;
    localparam int STAT_W   = 2;
    localparam int SIDX_W   = 5;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    localparam logic [KIND_W-1:0] K_READ    = 2'd0;
    localparam logic [KIND_W-1:0] K_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] K_PIN     = 2'd2;
    localparam logic [KIND_W-1:0] K_UNPIN   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO    = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT     = 2'd3;

    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic              valid;
        logic [REFS_W-1:0] refs;
        logic [BKT_W-1:0]  bucket;
        logic [RANK_W-1:0] rank;
    } t_slot;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [BKT_W-1:0] rem;
    } t_hash_stat;

endpackage

// ----- sv/hbbc_slot_table.sv -----
// ----------------------------------------------------------------------------
// hbbc_slot_table
// Slot records in flops, one read and one write port on a shared address.
// ----------------------------------------------------------------------------
module hbbc_slot_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [hbbc_pkg::SLOT_W-1:0] i_addr,
    input  logic                        i_wr_en,
    input  hbbc_pkg::t_slot             i_wr,
    output hbbc_pkg::t_slot             o_rd
);
    import hbbc_pkg::*;

    t_slot r_mem [SLOTS];

    assign o_rd = r_mem[i_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_mem[i].dev    <= '0;
                r_mem[i].blk    <= '0;
                r_mem[i].valid  <= 1'b0;
                r_mem[i].refs   <= '0;
                r_mem[i].bucket <= '0;
                r_mem[i].rank   <= RANK_W'(SLOTS - 1 - i);
            end
        end else if (i_wr_en) begin
            r_mem[i_addr] <= i_wr;
        end
    end

endmodule

// ----- sv/hbbc_hash_mod.sv -----
// ----------------------------------------------------------------------------
// hbbc_hash_mod
// Block number modulo bucket count, one nibble per cycle from the top.
// ----------------------------------------------------------------------------
module hbbc_hash_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hbbc_pkg::BLK_W-1:0] i_blk,
    output hbbc_pkg::t_hash_stat       o_stat
);
    import hbbc_pkg::*;

    localparam int NIB    = BLK_W / 4;
    localparam int CNT_W  = $clog2(NIB);
    localparam int ACC_W  = BKT_W + 4;

    logic [BLK_W-1:0] r_word;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [BKT_W-1:0] r_rem;
    logic [ACC_W-1:0] acc;

    always_comb begin
        acc = {r_rem, r_word[BLK_W-1 -: 4]};
        for (int k = 3; k >= 0; k--) begin
            if (acc >= ACC_W'(BUCKETS << k)) begin
                acc = acc - ACC_W'(BUCKETS << k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_word <= i_blk;
            end else if (r_busy) begin
                r_rem  <= acc[BKT_W-1:0];
                r_word <= r_word << 4;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NIB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat = '{busy: r_busy, done: r_done, rem: r_rem};

endmodule

// ----- sv/hashed_block_buffer_cache.sv -----
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache
// Hashed buffer slot cache with reference counts, scanned one slot a cycle.
// Read: the block number is hashed to a bucket, then all slots are scanned; a
//   steal adds a rank update pass over all slots.
// Pin/unpin: the indexed slot is updated directly; a release that drops to zero adds the rank
//   update. One request at a time; the slot table port sets the pace.
// Reset (synchronous, active low) clears all slots at once, ranks descending.
// ----------------------------------------------------------------------------
module hashed_block_buffer_cache (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [hbbc_pkg::KIND_W-1:0] i_kind,
    input  logic [hbbc_pkg::DEV_W-1:0]  i_dev,
    input  logic [hbbc_pkg::BLK_W-1:0]  i_block_number,
    input  logic [hbbc_pkg::SIDX_W-1:0] i_slot_index,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hbbc_pkg::SIDX_W-1:0] o_slot_out,
    output logic                        o_hit,
    output logic                        o_needs_disk_read,
    output logic [hbbc_pkg::STAT_W-1:0] o_status
);
    import hbbc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_HASH, S_SCAN, S_DECIDE, S_SLOT, S_FRONT, S_RESULT
    } t_state;

    t_state r_state, n_state;

    logic [SLOT_W-1:0] r_idx, n_idx;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [DEV_W-1:0]  r_dev, n_dev;
    logic [BLK_W-1:0]  r_blk, n_blk;
    logic [SIDX_W-1:0] r_si, n_si;
    logic [BKT_W-1:0]  r_h, n_h;

    logic              r_hit_f, n_hit_f;
    logic [SLOT_W-1:0] r_hit_idx, n_hit_idx;
    logic [RANK_W-1:0] r_hit_rank, n_hit_rank;
    logic              r_fr_f, n_fr_f;
    logic [SLOT_W-1:0] r_fr_idx, n_fr_idx;
    logic [BKT_W-1:0]  r_fr_bkt, n_fr_bkt;
    logic [RANK_W-1:0] r_fr_rank, n_fr_rank;

    logic [SLOT_W-1:0] r_tf_s, n_tf_s;
    logic [BKT_W-1:0]  r_tf_ob, n_tf_ob;
    logic [RANK_W-1:0] r_tf_orank, n_tf_orank;
    logic [BKT_W-1:0]  r_tf_nb, n_tf_nb;

    logic [SIDX_W-1:0] r_res_slot, n_res_slot;
    logic              r_res_hit, n_res_hit;
    logic              r_res_ndr, n_res_ndr;
    logic [STAT_W-1:0] r_res_status, n_res_status;

    logic              r_out_valid, n_out_valid;
    logic [SIDX_W-1:0] r_out_slot, n_out_slot;
    logic              r_out_hit, n_out_hit;
    logic              r_out_ndr, n_out_ndr;
    logic [STAT_W-1:0] r_out_status, n_out_status;

    logic [SLOT_W-1:0] tbl_addr;
    logic              tbl_we;
    t_slot             tbl_wd;
    t_slot             tbl_rd;
    logic              hash_start;
    t_hash_stat        hash_stat;
    logic              last;
    logic              dec;
    logic              inc;

    hbbc_slot_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (tbl_addr),
        .i_wr_en (tbl_we),
        .i_wr    (tbl_wd),
        .o_rd    (tbl_rd)
    );

    hbbc_hash_mod u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_blk   (i_block_number),
        .o_stat  (hash_stat)
    );

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_slot_out        = r_out_slot;
    assign o_hit             = r_out_hit;
    assign o_needs_disk_read = r_out_ndr;
    assign o_status          = r_out_status;

    assign last = (r_idx == SLOT_W'(SLOTS - 1));

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_kind       = r_kind;
        n_dev        = r_dev;
        n_blk        = r_blk;
        n_si         = r_si;
        n_h          = r_h;
        n_hit_f      = r_hit_f;
        n_hit_idx    = r_hit_idx;
        n_hit_rank   = r_hit_rank;
        n_fr_f       = r_fr_f;
        n_fr_idx     = r_fr_idx;
        n_fr_bkt     = r_fr_bkt;
        n_fr_rank    = r_fr_rank;
        n_tf_s       = r_tf_s;
        n_tf_ob      = r_tf_ob;
        n_tf_orank   = r_tf_orank;
        n_tf_nb      = r_tf_nb;
        n_res_slot   = r_res_slot;
        n_res_hit    = r_res_hit;
        n_res_ndr    = r_res_ndr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_slot   = r_out_slot;
        n_out_hit    = r_out_hit;
        n_out_ndr    = r_out_ndr;
        n_out_status = r_out_status;
        tbl_addr     = r_idx;
        tbl_we       = 1'b0;
        tbl_wd       = tbl_rd;
        hash_start   = 1'b0;
        dec          = 1'b0;
        inc          = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind       = i_kind;
                    n_dev        = i_dev;
                    n_blk        = i_block_number;
                    n_si         = i_slot_index;
                    n_res_slot   = i_slot_index;
                    n_res_hit    = 1'b0;
                    n_res_ndr    = 1'b0;
                    n_res_status = ST_OK;
                    if (i_kind == K_READ) begin
                        hash_start = 1'b1;
                        n_state    = S_HASH;
                    end else begin
                        n_state = S_SLOT;
                    end
                end
            end
            S_HASH: begin
                if (hash_stat.done) begin
                    n_h     = hash_stat.rem;
                    n_idx   = '0;
                    n_hit_f = 1'b0;
                    n_fr_f  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // lookup in own bucket and steal candidate (lowest bucket, then rank)
                if (tbl_rd.bucket == r_h && tbl_rd.dev == r_dev && tbl_rd.blk == r_blk
                        && (!r_hit_f || tbl_rd.rank < r_hit_rank)) begin
                    n_hit_f    = 1'b1;
                    n_hit_idx  = r_idx;
                    n_hit_rank = tbl_rd.rank;
                end
                if (tbl_rd.bucket != r_h && tbl_rd.refs == '0
                        && (!r_fr_f || tbl_rd.bucket < r_fr_bkt
                            || (tbl_rd.bucket == r_fr_bkt && tbl_rd.rank < r_fr_rank))) begin
                    n_fr_f    = 1'b1;
                    n_fr_idx  = r_idx;
                    n_fr_bkt  = tbl_rd.bucket;
                    n_fr_rank = tbl_rd.rank;
                end
                n_idx = r_idx + 1'b1;
                if (last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_RESULT;
                if (r_hit_f) begin
                    tbl_addr   = r_hit_idx;
                    n_res_slot = SIDX_W'(r_hit_idx);
                    n_res_hit  = 1'b1;
                    if (tbl_rd.refs >= REFS_MAX) begin
                        n_res_status = ST_SAT;
                    end else begin
                        tbl_we       = 1'b1;
                        tbl_wd.refs  = tbl_rd.refs + 1'b1;
                        tbl_wd.valid = 1'b1;
                        n_res_ndr    = !tbl_rd.valid;
                    end
                end else if (r_fr_f) begin
                    tbl_addr     = r_fr_idx;
                    tbl_we       = 1'b1;
                    tbl_wd.dev   = r_dev;
                    tbl_wd.blk   = r_blk;
                    tbl_wd.refs  = REFS_W'(1);
                    tbl_wd.valid = 1'b1;
                    n_res_slot   = SIDX_W'(r_fr_idx);
                    n_res_ndr    = 1'b1;
                    n_tf_s       = r_fr_idx;
                    n_tf_ob      = tbl_rd.bucket;
                    n_tf_orank   = tbl_rd.rank;
                    n_tf_nb      = r_h;
                    n_idx        = '0;
                    n_state      = S_FRONT;
                end else begin
                    n_res_slot   = '0;
                    n_res_status = ST_NO_FREE;
                end
            end
            S_SLOT: begin
                tbl_addr = SLOT_W'(r_si);
                n_state  = S_RESULT;
                if (32'(r_si) < SLOTS) begin
                    if (r_kind == K_PIN) begin
                        if (tbl_rd.refs >= REFS_MAX) begin
                            n_res_status = ST_SAT;
                        end else begin
                            tbl_we      = 1'b1;
                            tbl_wd.refs = tbl_rd.refs + 1'b1;
                        end
                    end else if (tbl_rd.refs == '0) begin
                        n_res_status = ST_ZERO;
                    end else begin
                        tbl_we      = 1'b1;
                        tbl_wd.refs = tbl_rd.refs - 1'b1;
                        if (r_kind == K_RELEASE && tbl_rd.refs == REFS_W'(1)) begin
                            n_tf_s     = SLOT_W'(r_si);
                            n_tf_ob    = tbl_rd.bucket;
                            n_tf_orank = tbl_rd.rank;
                            n_tf_nb    = tbl_rd.bucket;
                            n_idx      = '0;
                            n_state    = S_FRONT;
                        end
                    end
                end
            end
            S_FRONT: begin
                tbl_we = 1'b1;
                if (r_idx == r_tf_s) begin
                    tbl_wd.bucket = r_tf_nb;
                    tbl_wd.rank   = '0;
                end else begin
                    dec = (tbl_rd.bucket == r_tf_ob) && (tbl_rd.rank > r_tf_orank);
                    inc = (tbl_rd.bucket == r_tf_nb);
                    tbl_wd.rank = tbl_rd.rank + RANK_W'(inc) - RANK_W'(dec);
                end
                n_idx = r_idx + 1'b1;
                if (last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_hit    = r_res_hit;
                    n_out_ndr    = r_res_ndr;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_hit_f     <= 1'b0;
            r_fr_f      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_hit_f     <= n_hit_f;
            r_fr_f      <= n_fr_f;
        end
        r_kind       <= n_kind;
        r_dev        <= n_dev;
        r_blk        <= n_blk;
        r_si         <= n_si;
        r_h          <= n_h;
        r_hit_idx    <= n_hit_idx;
        r_hit_rank   <= n_hit_rank;
        r_fr_idx     <= n_fr_idx;
        r_fr_bkt     <= n_fr_bkt;
        r_fr_rank    <= n_fr_rank;
        r_tf_s       <= n_tf_s;
        r_tf_ob      <= n_tf_ob;
        r_tf_orank   <= n_tf_orank;
        r_tf_nb      <= n_tf_nb;
        r_res_slot   <= n_res_slot;
        r_res_hit    <= n_res_hit;
        r_res_ndr    <= n_res_ndr;
        r_res_status <= n_res_status;
        r_out_slot   <= n_out_slot;
        r_out_hit    <= n_out_hit;
        r_out_ndr    <= n_out_ndr;
        r_out_status <= n_out_status;
    end

endmodule
